>>> rtl/padded_run_distance_defines.svh
// Assertion macros for the padded run distance block
`ifndef PADDED_RUN_DISTANCE_DEFINES_SVH
`define PADDED_RUN_DISTANCE_DEFINES_SVH

// same-cycle implication
`define PRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/prd_pkg.sv
package prd_pkg;

   localparam int VOXEL_W = 16;
   localparam int DIST_W  = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic accept;
      logic emit_run;
      logic emit_tail;
   } cmd_type;

   typedef struct packed {
      logic padded;
      logic release_now;
      logic run_empty;
      logic run_one;
      logic tail_pending;
      logic out_free;
   } status_type;

endpackage

>>> rtl/padded_run_distance.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata voxel_value, tlast row_end
// rsp_      out        rsp_tvalid/rsp_tready  tdata distance, tuser is_padded/overflow,
//                                             tlast last_of_burst
// csr_      in         csr_valid/csr_ready    data pad_threshold
//
// A padding voxel inside a run is only counted. A voxel that releases a run of N voxels is
// followed by N flush results, one per cycle while the output is free; an unpadded voxel then
// adds its own result. The input is held off meanwhile.
// A single output register decouples the result side; rsp_tready low stalls the flush.
// Synchronous reset clears the threshold, the run count and the output valid.
module padded_run_distance #(
   parameter int ROW_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] voxel_value
   input  logic        req_tlast,  // row_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [6:0] distance, [7] zero
   output logic [1:0]  rsp_tuser,  // [0] is_padded, [1] overflow
   output logic        rsp_tlast,  // last_of_burst
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data    // pad_threshold
);
   import prd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   prd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prd_datapath #(
      .ROW_MAX (ROW_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/prd_ctrl.sv
module prd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  prd_pkg::status_type status,
   output prd_pkg::cmd_type    cmd
);
   import prd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.release_now) begin
               if (!status.padded && status.run_empty) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free && status.run_one) begin
               state_in = status.tail_pending ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_FLUSH: cmd.emit_run  = status.out_free;
         ST_TAIL:  cmd.emit_tail = status.out_free;
         default: ;
      endcase
   end

endmodule

>>> rtl/prd_datapath.sv
module prd_datapath #(
   parameter int ROW_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  prd_pkg::cmd_type           cmd,
   output prd_pkg::status_type        status,
   input  logic                       csr_valid,
   input  logic [prd_pkg::VOXEL_W-1:0] csr_data,
   input  logic [prd_pkg::VOXEL_W-1:0] req_tdata,
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);
   import prd_pkg::*;

   localparam int CNT_W = $clog2(ROW_MAX + 1);

   logic signed [VOXEL_W-1:0] thresh_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      ovf_ff;
   logic                      tail_ff;
   logic                      valid_ff;
   logic                      padded_out_ff;
   logic                      ovf_out_ff;
   logic                      last_out_ff;
   logic [DIST_W-1:0]         dist_out_ff;

   logic             padded;
   logic [CNT_W-1:0] count_inc;
   logic             load;

   assign padded    = $signed(req_tdata) <= thresh_ff;
   assign count_inc = count_ff + CNT_W'(1);
   assign load      = cmd.emit_run || cmd.emit_tail;

   assign status.padded       = padded;
   assign status.release_now  = !padded || req_tlast || (count_inc == CNT_W'(ROW_MAX));
   assign status.run_empty    = (count_ff == '0);
   assign status.run_one      = (count_ff == CNT_W'(1));
   assign status.tail_pending = tail_ff;
   assign status.out_free     = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (csr_valid) begin
         thresh_ff <= csr_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.accept && padded) begin
         count_in = count_inc;
      end else if (cmd.emit_run) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         tail_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.accept) begin
            ovf_ff  <= padded && !req_tlast;
            tail_ff <= !padded;
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_run) begin
         padded_out_ff <= 1'b1;
         dist_out_ff   <= DIST_W'(count_ff);
         ovf_out_ff    <= ovf_ff;
         last_out_ff   <= (count_ff == CNT_W'(1)) && !tail_ff;
      end else if (cmd.emit_tail) begin
         padded_out_ff <= 1'b0;
         dist_out_ff   <= '0;
         ovf_out_ff    <= 1'b0;
         last_out_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, dist_out_ff};
   assign rsp_tuser  = {ovf_out_ff, padded_out_ff};
   assign rsp_tlast  = last_out_ff;

endmodule

>>> rtl/prd_checker.sv
`include "padded_run_distance_defines.svh"

module prd_checker #(
   parameter int ROW_MAX = 64
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   `PRD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp changed while stalled")
   `PRD_ASSERT_NOW(a_unpadded_form, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 8'd0 && !rsp_tuser[1] && rsp_tlast, "bad unpadded result")
   `PRD_ASSERT_NOW(a_dist_range, rsp_tvalid && rsp_tuser[0], rsp_tdata != 8'd0 && rsp_tdata <= 8'(ROW_MAX), "distance out of range")
   `PRD_ASSERT_NOW(a_last_on_one, rsp_tvalid && rsp_tuser[0] && rsp_tdata != 8'd1, !rsp_tlast, "burst closed before distance one")

endmodule

bind padded_run_distance prd_checker #(
   .ROW_MAX (ROW_MAX)
) u_prd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
